// ===== design/por_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package por_pkg;

  // tree and stash geometry
  localparam int TREE_LEVELS   = 10;
  localparam int BUCKET_SLOTS  = 4;
  localparam int STASH_ENTRIES = 256;
  localparam int BLOCK_BYTES   = 64;

  localparam int WORDS       = BLOCK_BYTES / 8;
  localparam int FIELD_WORDS = 8;
  localparam int NUM_NODES   = (2 << TREE_LEVELS) - 1;

  localparam int LEAF_W  = TREE_LEVELS;
  localparam int NODE_W  = TREE_LEVELS + 1;
  localparam int ID_W    = 11;
  localparam int TAG_W   = ID_W + 1;
  localparam int ROW_W   = BUCKET_SLOTS * TAG_W;
  localparam int LVL_W   = $clog2(TREE_LEVELS + 2);
  localparam int STASH_W = $clog2(STASH_ENTRIES);
  localparam int SCAN_W  = $clog2(STASH_ENTRIES + 1);
  localparam int SLOT_W  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int CNT_W   = $clog2(BUCKET_SLOTS + 1);
  localparam int WD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NEED_W  = $clog2(BUCKET_SLOTS * (TREE_LEVELS + 1) + 2);
  localparam int CMP_W   = 16;

  localparam int BW_DEPTH = NUM_NODES * BUCKET_SLOTS * WORDS;
  localparam int BW_AW    = $clog2(BW_DEPTH);
  localparam int SW_DEPTH = STASH_ENTRIES * WORDS;
  localparam int SW_AW    = $clog2(SW_DEPTH);

  // request and result payloads
  typedef struct packed {
    logic        func;
    logic [10:0] block_id;
    logic [9:0]  new_leaf;
    logic [63:0] wdata_0;
    logic [63:0] wdata_1;
    logic [63:0] wdata_2;
    logic [63:0] wdata_3;
    logic [63:0] wdata_4;
    logic [63:0] wdata_5;
    logic [63:0] wdata_6;
    logic [63:0] wdata_7;
  } req_t;

  typedef struct packed {
    logic [63:0] rdata_0;
    logic [63:0] rdata_1;
    logic [63:0] rdata_2;
    logic [63:0] rdata_3;
    logic [63:0] rdata_4;
    logic [63:0] rdata_5;
    logic [63:0] rdata_6;
    logic [63:0] rdata_7;
    logic        stash_full;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/por_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module por_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/por_path_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// node on the path of x at a level, and whether leaf shares that node
module por_path_unit (
  input  logic [por_pkg::LEAF_W-1:0] x,
  input  logic [por_pkg::LEAF_W-1:0] leaf,
  input  logic [por_pkg::LVL_W-1:0]  lvl,
  output logic [por_pkg::NODE_W-1:0] node,
  output logic                       hit
);
  import por_pkg::*;

  logic [LVL_W-1:0] sh;

  assign sh   = LVL_W'(TREE_LEVELS) - lvl;
  assign node = NODE_W'(x >> sh) + (NODE_W'(1) << lvl) - NODE_W'(1);
  assign hit  = (leaf >> sh) == (x >> sh);

endmodule

`default_nettype wire

// ===== design/path_oram_access_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                          | payload
// ---------+--------------------------------+---------------------------
// request  | req_valid, req_stall, req_data | func, block_id, new_leaf, wdata
// result   | rsp_valid, rsp_stall, rsp_data | rdata, stash_full
//
// After reset the leaf map and bucket tags are swept to zero with req_stall
// high. One request at a time, each one running the one-entry-per-cycle
// stash scan (stash id RAM then leaf map RAM) at each of the 11 eviction
// levels, plus one word per cycle copies. An out-of-range block id goes
// straight to the result without a path access. The result register
// holds a result that is stalled; the next request may be taken meanwhile.
module path_oram_access_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  por_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output por_pkg::rsp_t rsp_data
);
  import por_pkg::*;

  typedef enum logic [22:0] {
    ST_CLEAR  = 23'h000001,
    ST_IDLE   = 23'h000002,
    ST_LOOK   = 23'h000004,
    ST_LOOKW  = 23'h000008,
    ST_PCNT   = 23'h000010,
    ST_SSCAN  = 23'h000020,
    ST_DECIDE = 23'h000040,
    ST_PROW   = 23'h000080,
    ST_PSLOT  = 23'h000100,
    ST_PFREE  = 23'h000200,
    ST_PCOPY  = 23'h000400,
    ST_PNEXT  = 23'h000800,
    ST_NFREE  = 23'h001000,
    ST_NZERO  = 23'h002000,
    ST_COMMIT = 23'h004000,
    ST_WRITE  = 23'h008000,
    ST_READ   = 23'h010000,
    ST_READL  = 23'h020000,
    ST_EVSCAN = 23'h040000,
    ST_EVCOPY = 23'h080000,
    ST_EVNEXT = 23'h100000,
    ST_EVTAG  = 23'h200000,
    ST_FIN    = 23'h400000
  } state_t;

  state_t state;

  logic [NODE_W-1:0]  clr_addr;
  logic               op_wr;
  logic [ID_W-1:0]    op_bid;
  logic [LEAF_W-1:0]  op_nl;
  logic [63:0]        op_wdata [FIELD_WORDS];
  logic [LEAF_W-1:0]  x;
  logic [LVL_W-1:0]   lvl;
  logic               pv;
  logic               pv2;
  logic [NEED_W-1:0]  pcnt;
  logic               found;
  logic [STASH_W-1:0] fe;
  logic [SCAN_W-1:0]  idx;
  logic [STASH_W-1:0] idx_d1;
  logic [STASH_W-1:0] idx_d2;
  logic [ID_W-1:0]    id_d2;
  logic [STASH_W-1:0] ptr;
  logic [SLOT_W-1:0]  slot;
  logic [WD_W-1:0]    wd;
  logic               cp_sw_we;
  logic [SW_AW-1:0]   cp_sw_addr;
  logic               cp_bw_we;
  logic [BW_AW-1:0]   cp_bw_addr;
  logic               rd_pv;
  logic [WD_W-1:0]    rd_w;
  logic [STASH_ENTRIES-1:0] valid;
  logic [SCAN_W-1:0]  vcnt;
  logic [CNT_W-1:0]   cnt;
  logic [STASH_W-1:0] sel    [BUCKET_SLOTS];
  logic [ID_W-1:0]    sel_id [BUCKET_SLOTS];
  logic [SLOT_W-1:0]  evs;
  logic [63:0]        res_data [FIELD_WORDS];
  logic               res_full;

  // RAM ports
  logic               lm_we, lm_re;
  logic [ID_W-1:0]    lm_waddr, lm_raddr;
  logic [LEAF_W-1:0]  lm_wdata, lm_rdata;
  logic               bt_we, bt_re;
  logic [NODE_W-1:0]  bt_waddr;
  logic [ROW_W-1:0]   bt_wdata, bt_rdata;
  logic               si_we, si_re;
  logic [STASH_W-1:0] si_waddr, si_raddr;
  logic [ID_W-1:0]    si_wdata, si_rdata;
  logic               sw_we, sw_re;
  logic [SW_AW-1:0]   sw_waddr, sw_raddr;
  logic [63:0]        sw_wdata, sw_rdata;
  logic               bw_we, bw_re;
  logic [BW_AW-1:0]   bw_waddr, bw_raddr;
  logic [63:0]        bw_wdata, bw_rdata;

  // helpers
  logic [NODE_W-1:0]  node_x;
  logic               leaf_hit;
  logic               lvl_issue;
  logic               idx_issue;
  logic               wd_last;
  logic               slot_last;
  logic [TAG_W-1:0]   cur_tag;
  logic               place;
  logic [NEED_W-1:0]  row_pop;
  logic               row_has_bid;
  logic [CMP_W-1:0]   need_cnt;
  logic [CMP_W-1:0]   free_cnt;
  logic [ROW_W-1:0]   ev_row;
  logic [SW_AW-1:0]   fe_waddr;
  logic [SW_AW-1:0]   ptr_waddr;
  logic [SW_AW-1:0]   sel_raddr;
  logic [BW_AW-1:0]   bw_path_addr;
  logic [BW_AW-1:0]   bw_ev_addr;

  por_path_unit u_path (
    .x    (x),
    .leaf (lm_rdata),
    .lvl  (lvl),
    .node (node_x),
    .hit  (leaf_hit)
  );

  por_ram #(.WIDTH(LEAF_W), .DEPTH(NUM_NODES)) u_leaf_map (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .re(lm_re), .raddr(lm_raddr), .rdata(lm_rdata)
  );

  por_ram #(.WIDTH(ROW_W), .DEPTH(NUM_NODES)) u_bucket_tags (
    .clk(clk), .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata),
    .re(bt_re), .raddr(node_x), .rdata(bt_rdata)
  );

  por_ram #(.WIDTH(64), .DEPTH(BW_DEPTH)) u_bucket_words (
    .clk(clk), .we(bw_we), .waddr(bw_waddr), .wdata(bw_wdata),
    .re(bw_re), .raddr(bw_raddr), .rdata(bw_rdata)
  );

  por_ram #(.WIDTH(ID_W), .DEPTH(STASH_ENTRIES)) u_stash_ids (
    .clk(clk), .we(si_we), .waddr(si_waddr), .wdata(si_wdata),
    .re(si_re), .raddr(si_raddr), .rdata(si_rdata)
  );

  por_ram #(.WIDTH(64), .DEPTH(SW_DEPTH)) u_stash_words (
    .clk(clk), .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
    .re(sw_re), .raddr(sw_raddr), .rdata(sw_rdata)
  );

  assign req_stall = (state != ST_IDLE);

  assign lvl_issue = (lvl <= LVL_W'(TREE_LEVELS));
  assign idx_issue = (idx < SCAN_W'(STASH_ENTRIES));
  assign wd_last   = (wd == WD_W'(WORDS - 1));
  assign slot_last = (slot == SLOT_W'(BUCKET_SLOTS - 1));
  assign cur_tag   = bt_rdata[slot*TAG_W +: TAG_W];
  assign place     = ((state == ST_PFREE) || (state == ST_NFREE)) && !valid[ptr];

  assign fe_waddr     = SW_AW'(fe) * SW_AW'(WORDS) + SW_AW'(wd);
  assign ptr_waddr    = SW_AW'(ptr) * SW_AW'(WORDS) + SW_AW'(wd);
  assign sel_raddr    = SW_AW'(sel[evs]) * SW_AW'(WORDS) + SW_AW'(wd);
  assign bw_path_addr = BW_AW'(node_x) * BW_AW'(BUCKET_SLOTS * WORDS)
                      + BW_AW'(slot) * BW_AW'(WORDS) + BW_AW'(wd);
  assign bw_ev_addr   = BW_AW'(node_x) * BW_AW'(BUCKET_SLOTS * WORDS)
                      + BW_AW'(evs) * BW_AW'(WORDS) + BW_AW'(wd);

  // path row occupancy and presence of the requested block
  always_comb begin
    row_pop     = '0;
    row_has_bid = 1'b0;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      if (bt_rdata[s*TAG_W + ID_W]) begin
        row_pop = row_pop + NEED_W'(1);
        if (bt_rdata[s*TAG_W +: ID_W] == op_bid) begin
          row_has_bid = 1'b1;
        end
      end
    end
  end

  assign need_cnt = CMP_W'(pcnt) + CMP_W'(!found);
  assign free_cnt = CMP_W'(SCAN_W'(STASH_ENTRIES) - vcnt);

  // bucket row written back at the end of a level
  always_comb begin
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      if (CNT_W'(s) < cnt) begin
        ev_row[s*TAG_W +: TAG_W] = {1'b1, sel_id[s]};
      end else begin
        ev_row[s*TAG_W +: TAG_W] = '0;
      end
    end
  end

  // RAM port steering
  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = op_bid;
    lm_wdata = op_nl;
    lm_re    = 1'b0;
    lm_raddr = op_bid;
    bt_we    = 1'b0;
    bt_waddr = node_x;
    bt_wdata = ev_row;
    bt_re    = 1'b0;
    si_we    = place;
    si_waddr = ptr;
    si_wdata = (state == ST_PFREE) ? cur_tag[ID_W-1:0] : op_bid;
    si_re    = 1'b0;
    si_raddr = idx[STASH_W-1:0];
    sw_we    = cp_sw_we;
    sw_waddr = cp_sw_addr;
    sw_wdata = bw_rdata;
    sw_re    = 1'b0;
    sw_raddr = fe_waddr;
    bw_we    = cp_bw_we;
    bw_waddr = cp_bw_addr;
    bw_wdata = sw_rdata;
    bw_re    = 1'b0;
    bw_raddr = bw_path_addr;
    unique case (state)
      ST_CLEAR: begin
        lm_we    = 1'b1;
        lm_waddr = clr_addr;
        lm_wdata = '0;
        bt_we    = 1'b1;
        bt_waddr = clr_addr;
        bt_wdata = '0;
      end
      ST_LOOK:   lm_re = 1'b1;
      ST_PCNT:   bt_re = lvl_issue;
      ST_SSCAN:  si_re = idx_issue;
      ST_PROW:   bt_re = 1'b1;
      ST_PCOPY:  bw_re = 1'b1;
      ST_NZERO: begin
        sw_we    = 1'b1;
        sw_waddr = fe_waddr;
        sw_wdata = '0;
      end
      ST_COMMIT: lm_we = 1'b1;
      ST_WRITE: begin
        sw_we    = 1'b1;
        sw_waddr = fe_waddr;
        sw_wdata = op_wdata[3'(wd)];
      end
      ST_READ:   sw_re = 1'b1;
      ST_EVSCAN: begin
        si_re    = idx_issue;
        lm_re    = pv;
        lm_raddr = si_rdata;
      end
      ST_EVCOPY: begin
        sw_re    = 1'b1;
        sw_raddr = sel_raddr;
      end
      ST_EVTAG:  bt_we = 1'b1;
      default: begin
      end
    endcase
  end

  // stash occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vcnt  <= '0;
    end else if (place) begin
      valid[ptr] <= 1'b1;
      vcnt       <= vcnt + SCAN_W'(1);
    end else if (state == ST_EVTAG) begin
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
        if (CNT_W'(s) < cnt) begin
          valid[sel[s]] <= 1'b0;
        end
      end
      vcnt <= vcnt - SCAN_W'(cnt);
    end
  end

  // word copy and readback pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_sw_we <= 1'b0;
      cp_bw_we <= 1'b0;
      rd_pv    <= 1'b0;
    end else begin
      cp_sw_we <= (state == ST_PCOPY);
      cp_bw_we <= (state == ST_EVCOPY);
      rd_pv    <= (state == ST_READ);
    end
    cp_sw_addr <= ptr_waddr;
    cp_bw_addr <= bw_ev_addr;
    rd_w       <= wd;
    if (rd_pv) begin
      res_data[3'(rd_w)] <= sw_rdata;
    end
    if ((state == ST_IDLE) && req_valid) begin
      for (int w = 0; w < FIELD_WORDS; w++) begin
        res_data[w] <= '0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
      pv        <= 1'b0;
      pv2       <= 1'b0;
    end else begin
      // the result register empties on acceptance unless refilled below
      if (rsp_valid && !rsp_stall && (state != ST_FIN)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == NODE_W'(NUM_NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op_wr       <= req_data.func;
            op_bid      <= req_data.block_id;
            op_nl       <= req_data.new_leaf;
            op_wdata[0] <= req_data.wdata_0;
            op_wdata[1] <= req_data.wdata_1;
            op_wdata[2] <= req_data.wdata_2;
            op_wdata[3] <= req_data.wdata_3;
            op_wdata[4] <= req_data.wdata_4;
            op_wdata[5] <= req_data.wdata_5;
            op_wdata[6] <= req_data.wdata_6;
            op_wdata[7] <= req_data.wdata_7;
            res_full    <= 1'b0;
            if (req_data.block_id >= ID_W'(NUM_NODES)) begin
              state <= ST_FIN;
            end else begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: state <= ST_LOOKW;
        ST_LOOKW: begin
          x     <= lm_rdata;
          lvl   <= '0;
          pcnt  <= '0;
          found <= 1'b0;
          pv    <= 1'b0;
          state <= ST_PCNT;
        end
        // count path blocks, note whether the block sits on the path
        ST_PCNT: begin
          pv <= lvl_issue;
          if (lvl_issue) begin
            lvl <= lvl + LVL_W'(1);
          end
          if (pv) begin
            pcnt <= pcnt + row_pop;
            if (row_has_bid) begin
              found <= 1'b1;
            end
          end
          if (!lvl_issue && !pv) begin
            idx   <= '0;
            state <= ST_SSCAN;
          end
        end
        // look for the block in the stash
        ST_SSCAN: begin
          pv     <= idx_issue;
          idx_d1 <= idx[STASH_W-1:0];
          if (idx_issue) begin
            idx <= idx + SCAN_W'(1);
          end
          if (pv && valid[idx_d1] && (si_rdata == op_bid)) begin
            found <= 1'b1;
            fe    <= idx_d1;
          end
          if (!idx_issue && !pv) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (need_cnt > free_cnt) begin
            res_full <= 1'b1;
            state    <= ST_FIN;
          end else begin
            lvl   <= '0;
            ptr   <= '0;
            state <= ST_PROW;
          end
        end
        // path read, slot by slot
        ST_PROW: begin
          slot  <= '0;
          state <= ST_PSLOT;
        end
        ST_PSLOT: begin
          if (cur_tag[TAG_W-1]) begin
            state <= ST_PFREE;
          end else begin
            state <= ST_PNEXT;
          end
        end
        ST_PFREE: begin
          if (!valid[ptr]) begin
            if (cur_tag[ID_W-1:0] == op_bid) begin
              fe <= ptr;
            end
            wd    <= '0;
            state <= ST_PCOPY;
          end else begin
            ptr <= ptr + STASH_W'(1);
          end
        end
        ST_PCOPY: begin
          wd <= wd + WD_W'(1);
          if (wd_last) begin
            state <= ST_PNEXT;
          end
        end
        ST_PNEXT: begin
          if (slot_last) begin
            slot <= '0;
            if (lvl == LVL_W'(TREE_LEVELS)) begin
              state <= found ? ST_COMMIT : ST_NFREE;
            end else begin
              lvl   <= lvl + LVL_W'(1);
              state <= ST_PROW;
            end
          end else begin
            slot  <= slot + SLOT_W'(1);
            state <= ST_PSLOT;
          end
        end
        // new block in the lowest free entry, zero filled
        ST_NFREE: begin
          if (!valid[ptr]) begin
            fe    <= ptr;
            wd    <= '0;
            state <= ST_NZERO;
          end else begin
            ptr <= ptr + STASH_W'(1);
          end
        end
        ST_NZERO: begin
          wd <= wd + WD_W'(1);
          if (wd_last) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          wd    <= '0;
          state <= op_wr ? ST_WRITE : ST_READ;
        end
        ST_WRITE: begin
          wd <= wd + WD_W'(1);
          if (wd_last) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          wd <= wd + WD_W'(1);
          if (wd_last) begin
            state <= ST_READL;
          end
        end
        ST_READL: begin
          lvl   <= LVL_W'(TREE_LEVELS);
          idx   <= '0;
          cnt   <= '0;
          pv    <= 1'b0;
          pv2   <= 1'b0;
          state <= ST_EVSCAN;
        end
        // eviction scan: id read, leaf read, path compare
        ST_EVSCAN: begin
          pv     <= idx_issue;
          idx_d1 <= idx[STASH_W-1:0];
          if (idx_issue) begin
            idx <= idx + SCAN_W'(1);
          end
          pv2    <= pv;
          idx_d2 <= idx_d1;
          id_d2  <= si_rdata;
          if (pv2 && valid[idx_d2] && (id_d2 < ID_W'(NUM_NODES)) && leaf_hit
              && (cnt < CNT_W'(BUCKET_SLOTS))) begin
            sel[cnt[SLOT_W-1:0]]    <= idx_d2;
            sel_id[cnt[SLOT_W-1:0]] <= id_d2;
            cnt                     <= cnt + CNT_W'(1);
          end
          if (!idx_issue && !pv && !pv2) begin
            evs   <= '0;
            wd    <= '0;
            state <= (cnt == '0) ? ST_EVTAG : ST_EVCOPY;
          end
        end
        ST_EVCOPY: begin
          wd <= wd + WD_W'(1);
          if (wd_last) begin
            state <= ST_EVNEXT;
          end
        end
        ST_EVNEXT: begin
          wd <= '0;
          if (CNT_W'(evs) + CNT_W'(1) == cnt) begin
            state <= ST_EVTAG;
          end else begin
            evs   <= evs + SLOT_W'(1);
            state <= ST_EVCOPY;
          end
        end
        ST_EVTAG: begin
          if (lvl == '0) begin
            state <= ST_FIN;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            idx   <= '0;
            cnt   <= '0;
            state <= ST_EVSCAN;
          end
        end
        // hand the result to the output register
        ST_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && (!rsp_valid || !rsp_stall)) begin
      rsp_data.rdata_0    <= res_data[0];
      rsp_data.rdata_1    <= res_data[1];
      rsp_data.rdata_2    <= res_data[2];
      rsp_data.rdata_3    <= res_data[3];
      rsp_data.rdata_4    <= res_data[4];
      rsp_data.rdata_5    <= res_data[5];
      rsp_data.rdata_6    <= res_data[6];
      rsp_data.rdata_7    <= res_data[7];
      rsp_data.stash_full <= res_full;
    end
  end

endmodule

`default_nettype wire

// ===== design/por_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module por_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire por_pkg::req_t req_data,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire por_pkg::rsp_t rsp_data
);

  // a stalled result stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp_data))
    else $error("result changed while stalled");

  // an overflowed access returns no data
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.stash_full |->
      (rsp_data.rdata_0 == 64'd0) && (rsp_data.rdata_1 == 64'd0) &&
      (rsp_data.rdata_2 == 64'd0) && (rsp_data.rdata_3 == 64'd0) &&
      (rsp_data.rdata_4 == 64'd0) && (rsp_data.rdata_5 == 64'd0) &&
      (rsp_data.rdata_6 == 64'd0) && (rsp_data.rdata_7 == 64'd0))
    else $error("data returned with stash_full");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // reset starts the clearing sweep
  a_clear: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request side open after reset");

endmodule

bind path_oram_access_core por_checker u_por_checker (.*);

`default_nettype wire
